[rtl/rbb_pkg.sv]
package rbb_pkg;

  // Frame geometry
  localparam int IMG_WIDTH  = 160;
  localparam int IMG_HEIGHT = 120;

  // Counter widths, wide enough to hold the frame size itself (tracker reset value)
  localparam int COL_W = $clog2(IMG_WIDTH + 1);
  localparam int ROW_W = $clog2(IMG_HEIGHT + 1);

  // Fixed field widths
  localparam int PIX_W    = 16;
  localparam int THR_W    = 8;
  localparam int CNT_W    = 15;
  localparam int OCOL_W   = 8;
  localparam int OROW_W   = 7;
  localparam int CFG_IX_W = 2;
  localparam int CFG_D_W  = 15;
  localparam int OUT_D_W  = 80;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IX_W-1:0] CFG_RED_THRESHOLD = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_MIN_RED_COUNT = 2'd1;

  localparam logic [THR_W-1:0] RED_THRESHOLD_RST = 8'd128;
  localparam logic [CNT_W-1:0] MIN_RED_COUNT_RST = 15'd100;

  // Queue between classifier and tracker
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One classified pixel
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             red;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } rbb_item_t;

  // Red test on a byte-swapped RGB565 word
  function automatic logic rbb_is_red(input logic [PIX_W-1:0] word,
                                      input logic [THR_W-1:0] thr);
    logic [15:0] p;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  half_r;
    p      = {word[7:0], word[15:8]};
    r      = {p[15:11], 3'b000};
    g      = {p[10:5], 2'b00};
    b      = {p[4:0], 3'b000};
    half_r = {1'b0, r[7:1]};
    return (r > thr) && (half_r > g) && (half_r > b);
  endfunction

endpackage

[rtl/red_blob_bounding_box.sv]
// A pixel is written into the queue, then moved from the queue head into the result
// register; an output stall or a backlog in the queue holds it back in between.
// One pixel per clock until the queue fills; a four-entry queue absorbs output stalls.
// The tracker compare chain (min/max update, then target test) sets the cycle time.
// Reset (rst_n low, synchronous): raster position, held report, queue and output valid
// cleared; trackers emptied (left, top at frame size); thresholds back to 128 and 100.
module red_blob_bounding_box (
  input  logic                             clk,
  input  logic                             rst_n,
  // Pixel stream in
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rbb_pkg::PIX_W-1:0]        in_tdata,  // [15:0] pixel_word
  // Result stream out
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] out_pixel, [16] found, [24:17] center_x, [31:25] center_y,
  // [39:32] box_left, [47:40] box_right, [54:48] box_top, [61:55] box_bottom,
  // [76:62] red_total, [79:77] zero
  output logic [rbb_pkg::OUT_D_W-1:0]      out_tdata,
  output logic                             out_tuser, // [0] pixel_is_red
  output logic                             out_tlast, // frame_done
  // Register writes
  input  logic                             cfg_we,
  input  logic [rbb_pkg::CFG_IX_W-1:0]     cfg_index,
  input  logic [rbb_pkg::CFG_D_W-1:0]      cfg_wdata
);
  import rbb_pkg::*;

  logic [THR_W-1:0] red_threshold_r;
  logic [CNT_W-1:0] min_red_count_r;

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  rbb_item_t q_item;
  rbb_item_t q_head;

  // Register file: writes to unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_threshold_r <= RED_THRESHOLD_RST;
      min_red_count_r <= MIN_RED_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RED_THRESHOLD: red_threshold_r <= cfg_wdata[THR_W-1:0];
        CFG_MIN_RED_COUNT: min_red_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: count raster position and classify each pixel
  rbb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .red_threshold (red_threshold_r),
    .pix_valid     (in_tvalid),
    .pix_data      (in_tdata),
    .q_full        (q_full),
    .pix_ready     (in_tready),
    .q_push        (q_push),
    .q_item        (q_item)
  );

  // Decouple front from back so an output stall does not stop the camera side at once
  rbb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: update box trackers, close frames, drive the result register
  rbb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .min_red_count (min_red_count_r),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_data      (out_tdata),
    .res_red       (out_tuser),
    .res_last      (out_tlast)
  );

endmodule

[rtl/rbb_front.sv]
module rbb_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rbb_pkg::THR_W-1:0]  red_threshold,
  input  logic                       pix_valid,
  input  logic [rbb_pkg::PIX_W-1:0]  pix_data,
  input  logic                       q_full,
  output logic                       pix_ready,
  output logic                       q_push,
  output rbb_pkg::rbb_item_t         q_item
);
  import rbb_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(IMG_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(IMG_HEIGHT - 1);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             last_col;
  logic             last_pix;

  assign pix_ready = !q_full;
  assign q_push    = pix_valid && pix_ready;
  assign last_col  = col_r >= LAST_COL;
  assign last_pix  = last_col && (row_r >= LAST_ROW);

  always_comb begin
    q_item.pixel = pix_data;
    q_item.red   = rbb_is_red(pix_data, red_threshold);
    q_item.last  = last_pix;
    q_item.col   = col_r;
    q_item.row   = row_r;
  end

  // Raster position advances once per item
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_pix ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[rtl/rbb_fifo.sv]
module rbb_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rbb_pkg::rbb_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output rbb_pkg::rbb_item_t head
);
  import rbb_pkg::*;

  rbb_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  localparam logic [FIFO_AW-1:0] LAST_PTR = FIFO_AW'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CW-1:0] FULL_CNT = FIFO_CW'(FIFO_DEPTH);

  assign full  = cnt_r == FULL_CNT;
  assign empty = cnt_r == '0;
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[rtl/rbb_back.sv]
module rbb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rbb_pkg::CNT_W-1:0]    min_red_count,
  input  logic                         q_empty,
  input  rbb_pkg::rbb_item_t           q_head,
  output logic                         q_pop,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [rbb_pkg::OUT_D_W-1:0]  res_data,
  output logic                         res_red,
  output logic                         res_last
);
  import rbb_pkg::*;

  // Running trackers
  logic [COL_W-1:0] run_left_r, run_left_nxt;
  logic [COL_W-1:0] run_right_r, run_right_nxt;
  logic [ROW_W-1:0] run_top_r, run_top_nxt;
  logic [ROW_W-1:0] run_bottom_r, run_bottom_nxt;
  logic [CNT_W-1:0] run_count_r, run_count_nxt;

  // Held report
  logic             held_found_r, held_found_nxt;
  logic [COL_W-1:0] held_left_r, held_left_nxt;
  logic [COL_W-1:0] held_right_r, held_right_nxt;
  logic [ROW_W-1:0] held_top_r, held_top_nxt;
  logic [ROW_W-1:0] held_bottom_r, held_bottom_nxt;
  logic [CNT_W-1:0] held_count_r, held_count_nxt;

  // Output stage
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pixel_r;
  logic               out_red_r;
  logic               out_last_r;
  logic               out_found_r;
  logic [OCOL_W-1:0]  out_cx_r, out_left_r, out_right_r;
  logic [OROW_W-1:0]  out_cy_r, out_top_r, out_bottom_r;
  logic [CNT_W-1:0]   out_count_r;

  logic [COL_W-1:0] upd_left, upd_right;
  logic [ROW_W-1:0] upd_top, upd_bottom;
  logic [CNT_W-1:0] upd_count;
  logic             target_ok;
  logic [COL_W:0]   col_sum;
  logic [ROW_W:0]   row_sum;

  assign q_pop = !q_empty && (!out_valid_r || res_ready);

  always_comb begin
    upd_left   = run_left_r;
    upd_right  = run_right_r;
    upd_top    = run_top_r;
    upd_bottom = run_bottom_r;
    upd_count  = run_count_r;
    if (q_head.red) begin
      if (q_head.col < run_left_r)   upd_left   = q_head.col;
      if (q_head.col > run_right_r)  upd_right  = q_head.col;
      if (q_head.row < run_top_r)    upd_top    = q_head.row;
      if (q_head.row > run_bottom_r) upd_bottom = q_head.row;
      if (run_count_r != COUNT_MAX)  upd_count  = run_count_r + 1'b1;
    end
    target_ok = (upd_count > min_red_count) && (upd_right > upd_left) &&
                (upd_bottom > upd_top);
  end

  always_comb begin
    run_left_nxt    = run_left_r;
    run_right_nxt   = run_right_r;
    run_top_nxt     = run_top_r;
    run_bottom_nxt  = run_bottom_r;
    run_count_nxt   = run_count_r;
    held_found_nxt  = held_found_r;
    held_left_nxt   = held_left_r;
    held_right_nxt  = held_right_r;
    held_top_nxt    = held_top_r;
    held_bottom_nxt = held_bottom_r;
    held_count_nxt  = held_count_r;
    if (q_pop) begin
      if (q_head.last) begin
        held_found_nxt = target_ok;
        if (target_ok) begin
          held_left_nxt   = upd_left;
          held_right_nxt  = upd_right;
          held_top_nxt    = upd_top;
          held_bottom_nxt = upd_bottom;
          held_count_nxt  = upd_count;
        end
        run_left_nxt   = COL_W'(IMG_WIDTH);
        run_right_nxt  = '0;
        run_top_nxt    = ROW_W'(IMG_HEIGHT);
        run_bottom_nxt = '0;
        run_count_nxt  = '0;
      end else begin
        run_left_nxt   = upd_left;
        run_right_nxt  = upd_right;
        run_top_nxt    = upd_top;
        run_bottom_nxt = upd_bottom;
        run_count_nxt  = upd_count;
      end
    end
  end

  assign col_sum = {1'b0, held_left_nxt} + {1'b0, held_right_nxt};
  assign row_sum = {1'b0, held_top_nxt} + {1'b0, held_bottom_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_left_r    <= COL_W'(IMG_WIDTH);
      run_right_r   <= '0;
      run_top_r     <= ROW_W'(IMG_HEIGHT);
      run_bottom_r  <= '0;
      run_count_r   <= '0;
      held_found_r  <= 1'b0;
      held_left_r   <= '0;
      held_right_r  <= '0;
      held_top_r    <= '0;
      held_bottom_r <= '0;
      held_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      run_left_r    <= run_left_nxt;
      run_right_r   <= run_right_nxt;
      run_top_r     <= run_top_nxt;
      run_bottom_r  <= run_bottom_nxt;
      run_count_r   <= run_count_nxt;
      held_found_r  <= held_found_nxt;
      held_left_r   <= held_left_nxt;
      held_right_r  <= held_right_nxt;
      held_top_r    <= held_top_nxt;
      held_bottom_r <= held_bottom_nxt;
      held_count_r  <= held_count_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_pixel_r  <= q_head.red ? '0 : q_head.pixel;
      out_red_r    <= q_head.red;
      out_last_r   <= q_head.last;
      out_found_r  <= held_found_nxt;
      out_cx_r     <= OCOL_W'(col_sum >> 1);
      out_cy_r     <= OROW_W'(row_sum >> 1);
      out_left_r   <= OCOL_W'(held_left_nxt);
      out_right_r  <= OCOL_W'(held_right_nxt);
      out_top_r    <= OROW_W'(held_top_nxt);
      out_bottom_r <= OROW_W'(held_bottom_nxt);
      out_count_r  <= held_count_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res_red   = out_red_r;
  assign res_last  = out_last_r;
  assign res_data  = {3'b000, out_count_r, out_bottom_r, out_top_r, out_right_r,
                      out_left_r, out_cy_r, out_cx_r, out_found_r, out_pixel_r};

endmodule

[rtl/rbb_checker.sv]
module rbb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rbb_pkg::OUT_D_W-1:0]      out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                      $stable(out_tuser) && $stable(out_tlast)))
    else $error("result changed while stalled");

  // A red pixel is passed on blacked out
  a_red_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[15:0] == 16'h0000))
    else $error("red pixel not blacked out");

  // A found target always has a box with extent
  a_found_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[16]) |->
      ((out_tdata[47:40] > out_tdata[39:32]) && (out_tdata[61:55] > out_tdata[54:48])))
    else $error("found without extent");

  // Center lies inside the held box
  a_center_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[16]) |->
      ((out_tdata[24:17] >= out_tdata[39:32]) && (out_tdata[24:17] <= out_tdata[47:40]) &&
       (out_tdata[31:25] >= out_tdata[54:48]) && (out_tdata[31:25] <= out_tdata[61:55])))
    else $error("center outside box");

endmodule

bind red_blob_bounding_box rbb_checker u_rbb_checker (.*);

[tb/red_blob_bounding_box_test.sv]
module red_blob_bounding_box_test;
  import rbb_pkg::*;

  // Run limit (timeout, in clock cycles)
  localparam int RUN_LIMIT    = 100_000;

  // Register indexes past the end of the register list: writes must be dropped
  localparam logic [CFG_IX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IX_W-1:0] CFG_SPARE_3 = 2'd3;

  // Report fields as packed on out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]        pad;
    logic [CNT_W-1:0]  red_total;
    logic [OROW_W-1:0] box_bottom;
    logic [OROW_W-1:0] box_top;
    logic [OCOL_W-1:0] box_right;
    logic [OCOL_W-1:0] box_left;
    logic [OROW_W-1:0] center_y;
    logic [OCOL_W-1:0] center_x;
    logic              found;
    logic [PIX_W-1:0]  out_pixel;
  } report_t;

  // One predicted result: report word plus tuser and tlast
  typedef struct packed {
    logic    frame_done;
    logic    is_red;
    report_t report;
  } pixel_result_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [PIX_W-1:0]    in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_D_W-1:0]  out_tdata;
  logic                out_tuser;
  logic                out_tlast;
  logic                cfg_we     = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index  = '0;
  logic [CFG_D_W-1:0]  cfg_wdata  = '0;

  red_blob_bounding_box dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pixels waiting to be sent, and results predicted for sent pixels
  logic [PIX_W-1:0] pixel_stream[$];
  pixel_result_t    predicted_pixels[$];

  // Register copies, kept in step with every write
  logic [THR_W-1:0] thr_reg       = RED_THRESHOLD_RST;
  logic [CNT_W-1:0] min_count_reg = MIN_RED_COUNT_RST;

  // Raster position and trackers of the predictor
  logic [COL_W-1:0]  scan_col   = '0;
  logic [ROW_W-1:0]  scan_row   = '0;
  logic [COL_W-1:0]  run_left   = COL_W'(IMG_WIDTH);
  logic [COL_W-1:0]  run_right  = '0;
  logic [ROW_W-1:0]  run_top    = ROW_W'(IMG_HEIGHT);
  logic [ROW_W-1:0]  run_bottom = '0;
  logic [CNT_W-1:0]  run_count  = '0;
  logic              held_found = 1'b0;
  logic [OCOL_W-1:0] held_left  = '0;
  logic [OCOL_W-1:0] held_right = '0;
  logic [OROW_W-1:0] held_top   = '0;
  logic [OROW_W-1:0] held_bottom = '0;
  logic [CNT_W-1:0]  held_count = '0;

  // Raster position of the next pixel queued by the stimulus
  int gen_col = 0;
  int gen_row = 0;

  int mismatches  = 0;
  int cycle_count = 0;

  // Sender burst/gap state and receiver ready pattern
  int          burst_left  = 0;
  int          gap_left    = 0;
  logic [31:0] ready_bits  = '1;
  logic [4:0]  ready_phase = '0;

  pixel_result_t want;
  report_t       got;

  // Color edge cases: black, white, pure red, threshold tie and one step above, green
  // tie and one below half red, blue either side of half red, pure green, blue, 5555, AAAA
  logic [PIX_W-1:0] edge_pixels [0:12] = '{
    16'h0000, 16'hFFFF, 16'h00F8, 16'h0080, 16'h0088, 16'hE0FB, 16'hC0FB,
    16'h0FF8, 16'h10F8, 16'hE007, 16'h1F00, 16'h5555, 16'hAAAA
  };

  // Red test: swap the bytes back, expand the three components to 8 bits
  function automatic logic pixel_passes_red(logic [PIX_W-1:0] word, logic [THR_W-1:0] thr);
    logic [15:0] swapped;
    logic [7:0]  red8;
    logic [7:0]  green8;
    logic [7:0]  blue8;
    swapped = {word[7:0], word[15:8]};
    red8    = {swapped[15:11], 3'b000};
    green8  = {swapped[10:5], 2'b00};
    blue8   = {swapped[4:0], 3'b000};
    return (red8 > thr) && ((red8 >> 1) > green8) && ((red8 >> 1) > blue8);
  endfunction

  function automatic void clear_run();
    run_left   = COL_W'(IMG_WIDTH);
    run_right  = '0;
    run_top    = ROW_W'(IMG_HEIGHT);
    run_bottom = '0;
    run_count  = '0;
  endfunction

  // Advance the predictor by one pixel and queue the result it must produce
  function automatic void track_pixel(logic [PIX_W-1:0] word);
    pixel_result_t res;
    logic          red;
    logic          last_col;
    logic          last_pix;
    logic [8:0]    sum_x;
    logic [7:0]    sum_y;
    red      = pixel_passes_red(word, thr_reg);
    last_col = (scan_col == COL_W'(IMG_WIDTH - 1));
    last_pix = last_col && (scan_row == ROW_W'(IMG_HEIGHT - 1));
    if (red) begin
      if (scan_col < run_left) run_left = scan_col;
      if (scan_col > run_right) run_right = scan_col;
      if (scan_row < run_top) run_top = scan_row;
      if (scan_row > run_bottom) run_bottom = scan_row;
      if (run_count != COUNT_MAX) run_count = run_count + 1'b1;
    end
    // Frame end: load the held report on a valid target, else only drop found
    if (last_pix) begin
      if (run_count > min_count_reg && run_right > run_left && run_bottom > run_top) begin
        held_found  = 1'b1;
        held_left   = run_left;
        held_right  = run_right;
        held_top    = run_top;
        held_bottom = run_bottom;
        held_count  = run_count;
      end else begin
        held_found = 1'b0;
      end
      clear_run();
    end
    if (last_col) begin
      scan_col = '0;
      scan_row = last_pix ? '0 : scan_row + 1'b1;
    end else begin
      scan_col = scan_col + 1'b1;
    end
    sum_x = held_left + held_right;
    sum_y = held_top + held_bottom;
    res.frame_done        = last_pix;
    res.is_red            = red;
    res.report.pad        = '0;
    res.report.out_pixel  = red ? '0 : word;
    res.report.found      = held_found;
    res.report.center_x   = sum_x[8:1];
    res.report.center_y   = sum_y[7:1];
    res.report.box_left   = held_left;
    res.report.box_right  = held_right;
    res.report.box_top    = held_top;
    res.report.box_bottom = held_bottom;
    res.report.red_total  = held_count;
    predicted_pixels.push_back(res);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endfunction

  function automatic void queue_word(logic [PIX_W-1:0] word);
    pixel_stream.push_back(word);
    if (gen_col == IMG_WIDTH - 1) begin
      gen_col = 0;
      gen_row = (gen_row == IMG_HEIGHT - 1) ? 0 : gen_row + 1;
    end else begin
      gen_col++;
    end
  endfunction

  // Queue n pixels: strongly red inside the box, background elsewhere.
  // Background is kept non-red except for noise_pct percent of raw random words.
  function automatic void queue_frame_part(int n, int left, int right, int top, int bottom,
                                           int noise_pct);
    logic [4:0]       r5;
    logic [5:0]       g6;
    logic [4:0]       b5;
    logic [PIX_W-1:0] word;
    repeat (n) begin
      if (gen_col >= left && gen_col <= right && gen_row >= top && gen_row <= bottom) begin
        // R >= 136, half R >= 68 beats G <= 60 and B <= 56: red for any threshold below 136
        r5 = $urandom_range(17, 31);
        g6 = $urandom_range(0, 15);
        b5 = $urandom_range(0, 7);
        word = {g6[2:0], b5, r5, g6[5:3]};
      end else begin
        word = $urandom;
        if ($urandom_range(0, 99) >= noise_pct)
          while (pixel_passes_red(word, thr_reg)) word = $urandom;
      end
      queue_word(word);
    end
  endfunction

  // Register write: present at one edge, taken by the block at the next
  task automatic write_reg(logic [CFG_IX_W-1:0] idx, logic [CFG_D_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RED_THRESHOLD: thr_reg = val[THR_W-1:0];
      CFG_MIN_RED_COUNT: min_count_reg = val;
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Threshold goes out with random upper bus bits, which must be ignored
  task automatic set_config(logic [THR_W-1:0] thr, logic [CNT_W-1:0] min_count);
    logic [CFG_D_W-THR_W-1:0] junk;
    junk = $urandom;
    write_reg(CFG_RED_THRESHOLD, {junk, thr});
    write_reg(CFG_MIN_RED_COUNT, min_count);
    finish_writes();
  endtask

  // Hold until every queued pixel is sent and every result has come back
  task automatic wait_idle();
    while (pixel_stream.size() != 0 || predicted_pixels.size() != 0) @(posedge clk);
  endtask

  // Driver: present the head of the pixel queue in bursts with random gaps;
  // never drop tvalid or change data while an item waits for tready.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_pixel(in_tdata);
        pixel_stream.delete(0);
        if (burst_left > 0) burst_left--;
      end
      if (!in_tvalid || in_tready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pixel_stream.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_stream[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: walk a 32-bit ready pattern, reloaded each lap as all ready,
  // half ready, mostly ready or mostly stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (ready_phase == 0) begin
        case ($urandom_range(0, 3))
          0: ready_bits = '1;
          1: ready_bits = $urandom;
          2: ready_bits = $urandom | $urandom;
          default: ready_bits = $urandom & $urandom;
        endcase
      end
      out_tready <= ready_bits[0];
      ready_bits  = {ready_bits[0], ready_bits[31:1]};
      ready_phase = ready_phase + 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (predicted_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: result with no pixel pending, expected none, actual %h",
                   $time, out_tdata);
      end else begin
        want = predicted_pixels.pop_front();
        check_field("pixel_is_red", want.is_red, out_tuser);
        check_field("frame_done", want.frame_done, out_tlast);
        check_field("out_pixel", want.report.out_pixel, got.out_pixel);
        check_field("found", want.report.found, got.found);
        check_field("center_x", want.report.center_x, got.center_x);
        check_field("center_y", want.report.center_y, got.center_y);
        check_field("box_left", want.report.box_left, got.box_left);
        check_field("box_right", want.report.box_right, got.box_right);
        check_field("box_top", want.report.box_top, got.box_top);
        check_field("box_bottom", want.report.box_bottom, got.box_bottom);
        check_field("red_total", want.report.red_total, got.red_total);
        check_field("pad", want.report.pad, got.pad);
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int left;
    int right;
    int top;
    int bottom;
    int noise;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Writes past the register list; the reset values must survive them
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, CFG_D_W'($urandom));
    finish_writes();

    // Color edge cases at reset thresholds, then a red band across the first two rows
    @(negedge clk);
    foreach (edge_pixels[i]) queue_word(edge_pixels[i]);
    left  = $urandom_range(20, 60);
    right = left + $urandom_range(10, 59);
    queue_frame_part(307, left, right, 0, 1, 0);

    // Random box with light noise under random settings
    wait_idle();
    set_config($urandom_range(0, 135), $urandom_range(0, 800));
    left   = $urandom_range(0, IMG_WIDTH - 1);
    right  = $urandom_range(left, IMG_WIDTH - 1);
    top    = $urandom_range(0, 3);
    bottom = $urandom_range(top, 4);
    noise  = $urandom_range(0, 5);
    @(negedge clk);
    queue_frame_part(240, left, right, top, bottom, noise);

    // Threshold at its top: nothing is red
    wait_idle();
    set_config('1, '0);
    @(negedge clk);
    queue_frame_part(80, 0, IMG_WIDTH - 1, 0, IMG_HEIGHT - 1, 100);

    // Raw random words under random settings
    wait_idle();
    set_config($urandom_range(0, 255), $urandom_range(0, 800));
    @(negedge clk);
    queue_frame_part(160, 0, -1, 0, -1, 100);

    // Drain, then give any stray result time to appear before the verdict
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
